>>> hw/rtl/pidaw_pkg.sv
package pidaw_pkg;

  // Filter weight of the old rate, Q8.
  localparam int unsigned FILTER_COEF_Q8 = 77;
  localparam int unsigned INTEGRAL_DEADBAND_Q16 = 32768;
  localparam int unsigned MAX_GAP_MS = 2000;
  localparam bit DERIV_ON_MEAS = 1'b1;

  // Rates and integral steps are scaled from milliseconds to seconds.
  localparam int unsigned MS_PER_S = 1000;

  localparam int MC_W = 51;
  localparam int ML_W = 33;
  localparam int PR_W = MC_W + ML_W;
  localparam int DV_W = 16;
  localparam int DD_W = 64;
  localparam int SUM_W = 54;

  localparam logic [MC_W-1:0] QLIM = MC_W'(51'h4_0000_0000_0000);

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_ERROR_DEADBAND,
    REG_DRIVE_MIN,
    REG_DRIVE_MAX,
    REG_INTEGRAL_BOUND,
    REG_CONTROL_MODE
  } reg_idx_t;

  // The min clamp is applied last so that it wins on crossed limits.
  function automatic logic [15:0] clamp_drive(logic signed [SUM_W-1:0] v,
                                              logic [15:0] dmin,
                                              logic [15:0] dmax);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic [15:0] r;
    hi = $signed({{(SUM_W-32){1'b0}}, dmax, 16'b0});
    lo = $signed({{(SUM_W-32){1'b0}}, dmin, 16'b0});
    if (v > hi) begin
      r = dmax;
    end else if (v < 0) begin
      r = 16'd0;
    end else begin
      r = v[31:16];
    end
    if (v < lo) begin
      r = dmin;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pid_controller_antiwindup.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     cmd, measurement, target, time_ms
// result    out        out_valid / out_stall   drive
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is worked at a time. A reset command, manual mode or a held sample
// goes straight to the result; a first sample needs one product; a full update
// runs through the bit-serial multiplier and the restoring divider, used in
// turn for every product and quotient.
// Reset is synchronous and restores the registers and controller state.
// A new item is taken while a finished result still waits under out_stall.
module pid_controller_antiwindup (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] measurement,
  input  logic [31:0] target,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] drive,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int MC_W = pidaw_pkg::MC_W;
  localparam int ML_W = pidaw_pkg::ML_W;
  localparam int PR_W = pidaw_pkg::PR_W;
  localparam int DV_W = pidaw_pkg::DV_W;
  localparam int DD_W = pidaw_pkg::DD_W;
  localparam int SUM_W = pidaw_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_MULEND, S_DIV, S_DIVEND, S_FILT1, S_FILT2,
    S_PRE, S_ISUM, S_FIN, S_FIRST, S_DONE
  } state_t;

  typedef enum logic [2:0] {OP_P, OP_RATE, OP_D, OP_I, OP_STEP} op_t;

  // Configuration registers.
  logic signed [31:0] gain_p, gain_i, gain_d;
  logic [30:0] error_deadband, integral_bound;
  logic [15:0] drive_min, drive_max;
  logic        control_mode;

  // Controller state.
  logic signed [31:0] isum;
  logic signed [47:0] fr;
  logic signed [31:0] prevm;
  logic signed [32:0] preve;
  logic [31:0] prevt;
  logic        first;
  logic [15:0] held;

  // Item and working registers.
  state_t state;
  op_t    op;
  logic        cmd_r;
  logic signed [31:0] meas_r, target_r;
  logic [31:0] time_r;
  logic signed [32:0] err_r;
  logic [32:0] aerr_r;
  logic [DV_W-1:0] dt_r;
  logic signed [51:0] p_r, d_r;
  logic signed [47:0] x_r;
  logic signed [55:0] tmp;
  logic signed [52:0] step_r;
  logic [15:0] res;
  logic neg;

  // Shared bit-serial multiplier and divider.
  logic [MC_W-1:0] mcand;
  logic [PR_W-1:0] prod;
  logic [5:0] mcnt;
  logic [DV_W-1:0] dvs, drem;
  logic [DD_W-1:0] quo;
  logic [5:0] dcnt;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      error_deadband <= '0;
      drive_min <= '0;
      drive_max <= 16'hffff;
      integral_bound <= 31'd32768000;
      control_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pidaw_pkg::REG_GAIN_P:         gain_p <= cfg_data;
        pidaw_pkg::REG_GAIN_I:         gain_i <= cfg_data;
        pidaw_pkg::REG_GAIN_D:         gain_d <= cfg_data;
        pidaw_pkg::REG_ERROR_DEADBAND: error_deadband <= cfg_data[30:0];
        pidaw_pkg::REG_DRIVE_MIN:      drive_min <= cfg_data[15:0];
        pidaw_pkg::REG_DRIVE_MAX:      drive_max <= cfg_data[15:0];
        pidaw_pkg::REG_INTEGRAL_BOUND: integral_bound <= cfg_data[30:0];
        pidaw_pkg::REG_CONTROL_MODE:   control_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Error with deadband, time step and derivative difference.
  logic signed [32:0] err_raw, errd;
  logic [32:0] aerr_raw, aerrd;
  logic [31:0] dt_full;
  logic signed [33:0] diff;
  logic [33:0] dmag;
  logic xneg;
  logic [31:0] gp_mag, gi_mag, gd_mag;

  always_comb begin
    err_raw = $signed({target_r[31], target_r}) - $signed({meas_r[31], meas_r});
    aerr_raw = err_raw[32] ? 33'(-err_raw) : 33'(err_raw);
    if (error_deadband != '0 && aerr_raw < {3'b0, error_deadband[30:1]}) begin
      errd = '0;
      aerrd = '0;
    end else begin
      errd = err_raw;
      aerrd = aerr_raw;
    end
    dt_full = time_r - prevt;
    if (pidaw_pkg::DERIV_ON_MEAS) begin
      diff = 34'(meas_r) - 34'(prevm);
    end else begin
      diff = 34'(errd) - 34'(preve);
    end
    dmag = diff[33] ? 34'(-diff) : 34'(diff);
    xneg = pidaw_pkg::DERIV_ON_MEAS ? !diff[33] : diff[33];
    gp_mag = gain_p[31] ? 32'(-gain_p) : 32'(gain_p);
    gi_mag = gain_i[31] ? 32'(-gain_i) : 32'(gain_i);
    gd_mag = gain_d[31] ? 32'(-gain_d) : 32'(gain_d);
  end

  // Multiplier step, product scaling with saturation, divider step.
  logic [MC_W:0] msum;
  logic [67:0] qhi;
  logic [MC_W-1:0] qmag;
  logic signed [51:0] qval;
  logic [DV_W:0] dsh, ddif;
  logic dge;

  always_comb begin
    msum = {1'b0, prod[PR_W-1:ML_W]} + (prod[0] ? {1'b0, mcand} : '0);
    qhi = prod[PR_W-1:16];
    qmag = (qhi > 68'(pidaw_pkg::QLIM)) ? pidaw_pkg::QLIM : qhi[MC_W-1:0];
    qval = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    dsh = {drem, quo[DD_W-1]};
    dge = (dsh >= {1'b0, dvs});
    ddif = dsh - {1'b0, dvs};
  end

  // Filter update, pre-saturation sum and integral update.
  logic signed [55:0] fsum;
  logic signed [47:0] fr_next;
  logic [47:0] fr_mag;
  logic signed [SUM_W-1:0] pre, isum_sum, bnd, total;
  logic sat_hi, sat_lo, integ;

  always_comb begin
    fsum = tmp + 56'(x_r) * $signed(56'(256 - pidaw_pkg::FILTER_COEF_Q8));
    fr_next = 48'(fsum >>> 8);
    fr_mag = fr_next[47] ? 48'(-fr_next) : 48'(fr_next);
    pre = SUM_W'(p_r) + SUM_W'(isum) + SUM_W'(d_r);
    sat_hi = pre > $signed({{(SUM_W-32){1'b0}}, drive_max, 16'b0});
    sat_lo = pre < $signed({{(SUM_W-32){1'b0}}, drive_min, 16'b0});
    integ = (!(sat_hi || sat_lo) || (sat_hi && err_r < 0) || (!sat_hi && err_r > 0))
            && (aerr_r > 33'(pidaw_pkg::INTEGRAL_DEADBAND_Q16));
    isum_sum = SUM_W'(isum) + SUM_W'(step_r);
    bnd = $signed({{(SUM_W-31){1'b0}}, integral_bound});
    total = pre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      isum <= '0;
      fr <= '0;
      prevm <= '0;
      preve <= '0;
      prevt <= '0;
      first <= 1'b1;
      held <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            meas_r <= measurement;
            target_r <= target;
            time_r <= time_ms;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          err_r <= errd;
          aerr_r <= aerrd;
          dt_r <= dt_full[DV_W-1:0];
          d_r <= '0;
          if (cmd_r || (control_mode && !first && dt_full > 32'(pidaw_pkg::MAX_GAP_MS))) begin
            isum <= '0;
            fr <= '0;
            first <= 1'b1;
            held <= '0;
            res <= '0;
            if (cmd_r) begin
              prevm <= '0;
              preve <= '0;
              prevt <= '0;
            end else begin
              prevm <= meas_r;
              preve <= errd;
              prevt <= time_r;
            end
            state <= S_DONE;
          end else if (!control_mode || (!first && dt_full == '0)) begin
            res <= held;
            state <= S_DONE;
          end else if (!first && gain_d != '0) begin
            op <= OP_RATE;
            mcand <= MC_W'(dmag);
            prod <= PR_W'(pidaw_pkg::MS_PER_S);
            neg <= xneg;
            mcnt <= '0;
            state <= S_MUL;
          end else begin
            op <= OP_P;
            mcand <= MC_W'(aerrd);
            prod <= PR_W'(gp_mag);
            neg <= gain_p[31] ^ errd[32];
            mcnt <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= {msum, prod[ML_W-1:1]};
          mcnt <= mcnt + 6'd1;
          if (mcnt == 6'(ML_W - 1)) begin
            state <= S_MULEND;
          end
        end
        S_MULEND: begin
          case (op)
            OP_P: begin
              p_r <= qval;
              state <= first ? S_FIRST : S_PRE;
            end
            OP_RATE: begin
              quo <= prod[DD_W-1:0];
              drem <= '0;
              dvs <= dt_r;
              dcnt <= '0;
              state <= S_DIV;
            end
            OP_D: begin
              d_r <= qval;
              op <= OP_P;
              mcand <= MC_W'(aerr_r);
              prod <= PR_W'(gp_mag);
              neg <= gain_p[31] ^ err_r[32];
              mcnt <= '0;
              state <= S_MUL;
            end
            OP_I: begin
              op <= OP_STEP;
              mcand <= qmag;
              prod <= PR_W'(dt_r);
              mcnt <= '0;
              state <= S_MUL;
            end
            OP_STEP: begin
              quo <= prod[DD_W-1:0];
              drem <= '0;
              dvs <= DV_W'(pidaw_pkg::MS_PER_S);
              dcnt <= '0;
              state <= S_DIV;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          drem <= dge ? ddif[DV_W-1:0] : dsh[DV_W-1:0];
          quo <= {quo[DD_W-2:0], dge};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(DD_W - 1)) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          if (op == OP_RATE) begin
            x_r <= neg ? -$signed({1'b0, quo[46:0]}) : $signed({1'b0, quo[46:0]});
            state <= S_FILT1;
          end else begin
            step_r <= neg ? -$signed({1'b0, quo[51:0]}) : $signed({1'b0, quo[51:0]});
            state <= S_ISUM;
          end
        end
        S_FILT1: begin
          tmp <= 56'(fr) * $signed(56'(pidaw_pkg::FILTER_COEF_Q8));
          state <= S_FILT2;
        end
        S_FILT2: begin
          fr <= fr_next;
          op <= OP_D;
          mcand <= MC_W'(fr_mag);
          prod <= PR_W'(gd_mag);
          neg <= gain_d[31] ^ fr_next[47];
          mcnt <= '0;
          state <= S_MUL;
        end
        S_PRE: begin
          if (integ) begin
            op <= OP_I;
            mcand <= MC_W'(aerr_r);
            prod <= PR_W'(gi_mag);
            neg <= gain_i[31] ^ err_r[32];
            mcnt <= '0;
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_ISUM: begin
          if (isum_sum > bnd) begin
            isum <= bnd[31:0];
          end else if (isum_sum < -bnd) begin
            isum <= 32'(-bnd);
          end else begin
            isum <= isum_sum[31:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          held <= pidaw_pkg::clamp_drive(total, drive_min, drive_max);
          res <= pidaw_pkg::clamp_drive(total, drive_min, drive_max);
          prevt <= time_r;
          prevm <= meas_r;
          preve <= err_r;
          state <= S_DONE;
        end
        S_FIRST: begin
          held <= pidaw_pkg::clamp_drive(SUM_W'(p_r), drive_min, drive_max);
          res <= pidaw_pkg::clamp_drive(SUM_W'(p_r), drive_min, drive_max);
          prevt <= time_r;
          prevm <= meas_r;
          preve <= err_r;
          first <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            drive <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted item keeps the input side closed on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (drem < dvs))
    else $error("divider remainder out of range");

  // The multiplier never runs past its last bit.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (mcnt < 6'(ML_W)))
    else $error("multiplier count overrun");

  // Before the first sample the integral and the filter are clear.
  assert property (@(posedge clk) disable iff (rst)
    first |-> (isum == '0 && fr == '0))
    else $error("state not clear before first sample");

endmodule

>>> tb/tb.sv
module tb;

  typedef struct packed {
    logic        cmd;
    logic [31:0] measurement;
    logic [31:0] target;
    logic [31:0] time_ms;
  } sample_t;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [31:0] measurement = '0;
  logic [31:0] target = '0;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] drive;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pid_controller_antiwindup dut (.*);

  always #5 clk = ~clk;

  // Predictor state and configuration copy.
  longint kp, ki, kd;
  longint band, dmin, dmax, ibound;
  bit     auto_mode;
  longint isum, frate, last_meas, last_err;
  logic [31:0] last_time;
  bit     fresh;
  logic [15:0] hold_drive;

  logic [15:0] drive_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  long_hold = 1'b0;
  logic [31:0] clock_ms = 0;

  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, m;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    if (ua > (64'd1 << 31)) ua = 64'd1 << 31;
    if (ub > (64'd1 << 48)) ub = 64'd1 << 48;
    m = ua * (ub >> 16) + ((ua * (ub & 64'hffff)) >> 16);
    if (m > (64'd1 << 50)) m = 64'd1 << 50;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [15:0] limit_drive(longint v);
    logic [15:0] r;
    if (v > (dmax <<< 16)) r = dmax[15:0];
    else if (v < 0) r = '0;
    else r = v[31:16];
    if (v < (dmin <<< 16)) r = dmin[15:0];
    return r;
  endfunction

  function automatic void clear_loop();
    isum = 0; frate = 0; last_meas = 0; last_err = 0;
    last_time = 0; fresh = 1; hold_drive = 0;
  endfunction

  function automatic logic [15:0] predict_drive(sample_t s);
    longint meas, e, ae, dterm, pterm, pre, x;
    logic [31:0] dt;
    bit hi, lo;
    dterm = 0;
    if (s.cmd) begin
      clear_loop();
      return hold_drive;
    end
    if (!auto_mode) return hold_drive;
    meas = longint'($signed(s.measurement));
    e = longint'($signed(s.target)) - meas;
    ae = e < 0 ? -e : e;
    if (band > 0 && ae < (band >> 1)) begin
      e = 0; ae = 0;
    end
    if (fresh) begin
      last_meas = meas; last_err = e; last_time = s.time_ms; fresh = 0;
      hold_drive = limit_drive(fx_mul(kp, e));
      return hold_drive;
    end
    dt = s.time_ms - last_time;
    if (dt == 0) return hold_drive;
    if (dt > pidaw_pkg::MAX_GAP_MS) begin
      clear_loop();
      fresh = 1;
      last_time = s.time_ms; last_meas = meas; last_err = e;
      return hold_drive;
    end
    if (kd != 0) begin
      if (pidaw_pkg::DERIV_ON_MEAS) x = -(((meas - last_meas) * 1000) / longint'(dt));
      else x = ((e - last_err) * 1000) / longint'(dt);
      frate = (longint'(pidaw_pkg::FILTER_COEF_Q8) * frate
               + longint'(256 - pidaw_pkg::FILTER_COEF_Q8) * x) >>> 8;
      dterm = fx_mul(kd, frate);
    end
    pterm = fx_mul(kp, e);
    pre = pterm + isum + dterm;
    hi = pre > (dmax <<< 16);
    lo = pre < (dmin <<< 16);
    if (!(hi || lo) || (hi && e < 0) || (!hi && e > 0)) begin
      if (ae > pidaw_pkg::INTEGRAL_DEADBAND_Q16) begin
        isum += (fx_mul(ki, e) * longint'(dt)) / 1000;
        if (isum > ibound) isum = ibound;
        else if (isum < -ibound) isum = -ibound;
      end
    end
    hold_drive = limit_drive(pterm + isum + dterm);
    last_time = s.time_ms; last_meas = meas; last_err = e;
    return hold_drive;
  endfunction

  task automatic send_sample(sample_t s);
    if (!quiet) begin
      while ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    {cmd, measurement, target, time_ms} <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    drive_q.push_back(predict_drive(s));
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (drive_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(pidaw_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pidaw_pkg::REG_GAIN_P: kp = longint'($signed(val));
      pidaw_pkg::REG_GAIN_I: ki = longint'($signed(val));
      pidaw_pkg::REG_GAIN_D: kd = longint'($signed(val));
      pidaw_pkg::REG_ERROR_DEADBAND: band = val[30:0];
      pidaw_pkg::REG_DRIVE_MIN: dmin = val[15:0];
      pidaw_pkg::REG_DRIVE_MAX: dmax = val[15:0];
      pidaw_pkg::REG_INTEGRAL_BOUND: ibound = val[30:0];
      pidaw_pkg::REG_CONTROL_MODE: auto_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Moderate measurements near a randomly chosen setpoint, with mostly short time steps.
  function automatic sample_t tracking_sample();
    sample_t s;
    s.cmd = ($urandom_range(0, 60) == 0);
    s.target = 32'(int'($urandom_range(0, 200)) <<< 16);
    s.measurement = s.target + 32'($signed(20'($urandom)));
    case ($urandom_range(0, 19))
      0: clock_ms += 0;
      1: clock_ms += 32'($urandom_range(2001, 5000));
      2: clock_ms += 2000;
      default: clock_ms += 32'($urandom_range(1, 50));
    endcase
    s.time_ms = clock_ms;
    return s;
  endfunction

  function automatic sample_t noise_sample();
    sample_t s;
    s.cmd = 1'($urandom_range(0, 1));
    s.measurement = $urandom;
    s.target = $urandom;
    s.time_ms = $urandom_range(0, 3) == 0 ? $urandom : clock_ms + $urandom_range(0, 3000);
    clock_ms = s.time_ms;
    return s;
  endfunction

  task automatic test_defaults();
    sample_t s;
    s = '{cmd: 1'b0, measurement: 32'h8000_0000, target: 32'h7fff_ffff, time_ms: 0};
    send_sample(s);
    s.time_ms = 5; send_sample(s);
    s.time_ms = 5; send_sample(s);
    s = '{cmd: 1'b1, measurement: 0, target: 0, time_ms: 0};
    send_sample(s);
    drain();
  endtask

  task automatic test_special_cases();
    sample_t s;
    write_reg(pidaw_pkg::REG_GAIN_P, 32'h0002_0000);
    write_reg(pidaw_pkg::REG_GAIN_I, 32'h0001_0000);
    write_reg(pidaw_pkg::REG_GAIN_D, 32'h0000_8000);
    write_reg(pidaw_pkg::REG_ERROR_DEADBAND, 32'h0002_0000);
    write_reg(pidaw_pkg::REG_DRIVE_MIN, 32'd10);
    write_reg(pidaw_pkg::REG_DRIVE_MAX, 32'd1000);
    write_reg(pidaw_pkg::REG_INTEGRAL_BOUND, 32'h0064_0000);
    // Small error inside the deadband on the first sample, then an update, a held sample, a long gap.
    s = '{cmd: 1'b0, measurement: 32'h0010_0000, target: 32'h0010_8000, time_ms: 100};
    send_sample(s);
    s.target = 32'h0030_0000; s.time_ms = 110; send_sample(s);
    s.time_ms = 110; send_sample(s);
    s.measurement = 32'h0020_0000; s.time_ms = 130; send_sample(s);
    s.time_ms = 2130; send_sample(s);
    s.time_ms = 4200; send_sample(s);
    s.time_ms = 4210; send_sample(s);
    s.target = 32'h7fff_ffff; s.measurement = 32'h8000_0000; s.time_ms = 4211;
    send_sample(s);
    s.target = 32'h8000_0000; s.measurement = 32'h7fff_ffff; s.time_ms = 4212;
    send_sample(s);
    s.time_ms = 32'hffff_fff0; send_sample(s);
    s.time_ms = 32'h0000_0005; send_sample(s);
    drain();
    write_reg(pidaw_pkg::REG_CONTROL_MODE, 32'd0);
    s.time_ms = 20; send_sample(s);
    s.cmd = 1'b1; send_sample(s);
    drain();
    write_reg(pidaw_pkg::REG_CONTROL_MODE, 32'd1);
    // Crossed limits: the lower bound wins.
    write_reg(pidaw_pkg::REG_DRIVE_MIN, 32'd2000);
    write_reg(pidaw_pkg::REG_DRIVE_MAX, 32'd100);
    s = '{cmd: 1'b0, measurement: 0, target: 32'h0100_0000, time_ms: 7};
    send_sample(s);
    s.time_ms = 8; send_sample(s);
    drain();
  endtask

  task automatic random_phase(int count, bit with_noise);
    repeat (count) begin
      if (with_noise && $urandom_range(0, 4) == 0) send_sample(noise_sample());
      else send_sample(tracking_sample());
    end
    drain();
  endtask

  task automatic randomize_config();
    write_reg(pidaw_pkg::REG_GAIN_P,
              $urandom_range(0, 3) == 0 ? $urandom : 32'($signed(20'($urandom))));
    write_reg(pidaw_pkg::REG_GAIN_I,
              $urandom_range(0, 3) == 0 ? $urandom : 32'($signed(20'($urandom))));
    write_reg(pidaw_pkg::REG_GAIN_D,
              $urandom_range(0, 3) == 0 ? 32'd0 : 32'($signed(18'($urandom))));
    write_reg(pidaw_pkg::REG_ERROR_DEADBAND,
              $urandom_range(0, 1) ? $urandom_range(0, 65536) : $urandom);
    write_reg(pidaw_pkg::REG_DRIVE_MIN, $urandom_range(0, 300));
    write_reg(pidaw_pkg::REG_DRIVE_MAX, $urandom_range(0, 5) == 0 ? $urandom_range(0, 65535)
                                                                   : $urandom_range(500, 65535));
    write_reg(pidaw_pkg::REG_INTEGRAL_BOUND,
              $urandom_range(0, 2) == 0 ? $urandom : 32'h01f4_0000);
    write_reg(pidaw_pkg::REG_CONTROL_MODE, 32'($urandom_range(0, 5) != 0));
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (6) send_sample(tracking_sample());
    drain();
  endtask

  task automatic test_extreme_config();
    write_reg(pidaw_pkg::REG_GAIN_P, 32'h8000_0000);
    write_reg(pidaw_pkg::REG_GAIN_I, 32'h7fff_ffff);
    write_reg(pidaw_pkg::REG_GAIN_D, 32'h7fff_ffff);
    write_reg(pidaw_pkg::REG_ERROR_DEADBAND, 32'h7fff_ffff);
    write_reg(pidaw_pkg::REG_DRIVE_MIN, 32'd0);
    write_reg(pidaw_pkg::REG_DRIVE_MAX, 32'h0000_ffff);
    write_reg(pidaw_pkg::REG_INTEGRAL_BOUND, 32'h7fff_ffff);
    random_phase(20, 1'b1);
    write_reg(pidaw_pkg::REG_ERROR_DEADBAND, 32'd0);
    write_reg(pidaw_pkg::REG_INTEGRAL_BOUND, 32'd0);
    write_reg(pidaw_pkg::REG_GAIN_P, 32'h7fff_ffff);
    write_reg(pidaw_pkg::REG_GAIN_D, 32'h8000_0000);
    random_phase(20, 1'b1);
  endtask

  // Receiver side: random stall bursts, or one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
    end else if (out_stall && !quiet && $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        $error("unexpected result: drive=%0d", drive);
        errors++;
      end else begin
        if (drive !== drive_q[0]) begin
          $error("drive mismatch: expected %0d, actual %0d", drive_q[0], drive);
          errors++;
        end
        void'(drive_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The long hold-off ends after its own count of cycles.
  initial begin
    int n;
    forever begin
      @(posedge long_hold);
      n = 0;
      while (n < 2000) begin
        @(posedge clk);
        n++;
      end
      long_hold = 1'b0;
    end
  end

  initial begin
    kp = 0; ki = 0; kd = 0; band = 0; dmin = 0; dmax = 65535;
    ibound = 32768000; auto_mode = 1;
    clear_loop();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_defaults();
    test_special_cases();
    test_backpressure();
    test_extreme_config();
    repeat (6) begin
      randomize_config();
      random_phase(60, 1'b1);
    end
    write_reg(pidaw_pkg::REG_CONTROL_MODE, 32'd1);
    quiet = 1'b1;
    random_phase(120, 1'b0);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> pid_controller_antiwindup.f
hw/rtl/pidaw_pkg.sv
hw/rtl/pid_controller_antiwindup.sv
tb/tb.sv
